@@ hw/rtl/wlf_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and saturating helpers for the weighted line fit.
// No dependencies; used by every module of the block.
package wlf_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
    localparam logic [6:0] DIV_TOP_FULL = 7'd127;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef struct packed {
        logic               sat;
        logic signed [63:0] v;
    } t_sres;

    // result beat of an arithmetic unit
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [63:0] res;
    } t_unit_out;

    function automatic logic [63:0] f_mag(input logic signed [63:0] a);
        return a[63] ? 64'(-a) : 64'(a);
    endfunction

    function automatic t_sres f_qadd(input logic signed [63:0] a, input logic signed [63:0] b);
        t_sres r;
        logic signed [63:0] s;
        s = a + b;
        r.sat = (a[63] == b[63]) && (s[63] != a[63]);
        r.v = r.sat ? (a[63] ? Q_MIN : Q_MAX) : s;
        return r;
    endfunction

    function automatic t_sres f_qsub(input logic signed [63:0] a, input logic signed [63:0] b);
        t_sres r;
        logic signed [63:0] s;
        s = a - b;
        r.sat = (a[63] != b[63]) && (s[63] != a[63]);
        r.v = r.sat ? (a[63] ? Q_MIN : Q_MAX) : s;
        return r;
    endfunction

endpackage

@@ hw/rtl/wlf_mul.sv @@
`timescale 1ns / 1ps
// Fixed-point multiply, truncating and saturating, built from four 32x32 partial
// products accumulated one after another. Depends on wlf_pkg.
module wlf_mul #(
    parameter int FRAC_BITS = wlf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    output wlf_pkg::t_unit_out  o_out
);

    logic [63:0]  r_ma, r_mb;
    logic         r_neg;
    logic [127:0] r_acc;
    logic [2:0]   r_step;
    logic         r_run;
    logic         r_done;
    logic         r_sat;
    logic signed [63:0] r_res;

    logic [31:0]  opa, opb;
    logic [63:0]  pp;
    logic [1:0]   sh;
    logic [127:0] addend;
    logic         hi_nz;
    logic [63:0]  fin_mag;
    logic         fin_sat;

    always_comb begin
        opa = r_step[0] ? r_ma[63:32] : r_ma[31:0];
        opb = r_step[1] ? r_mb[63:32] : r_mb[31:0];
        pp  = opa * opb;
        sh  = {1'b0, r_step[0]} + {1'b0, r_step[1]};
        addend = {64'd0, pp} << {sh, 5'd0};
        hi_nz  = |r_acc[127:64+FRAC_BITS];
        fin_mag = hi_nz ? 64'(wlf_pkg::Q_MAX) : r_acc[63+FRAC_BITS -: 64];
        fin_sat = hi_nz | fin_mag[63];
        if (fin_mag[63]) begin
            fin_mag = 64'(wlf_pkg::Q_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
            end else if (r_run && r_step == 3'd4) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma   <= wlf_pkg::f_mag(i_a);
            r_mb   <= wlf_pkg::f_mag(i_b);
            r_neg  <= i_a[63] ^ i_b[63];
            r_acc  <= '0;
            r_step <= '0;
        end else if (r_run) begin
            if (r_step == 3'd4) begin
                r_sat <= fin_sat;
                r_res <= r_neg ? -$signed(fin_mag) : $signed(fin_mag);
            end else begin
                r_acc  <= r_acc + addend;
                r_step <= r_step + 3'd1;
            end
        end
    end

    assign o_out = '{done: r_done, sat: r_sat, res: r_res};

endmodule

@@ hw/rtl/wlf_div.sv @@
`timescale 1ns / 1ps
// Fixed-point divide (a << FRAC_BITS) / b, restoring, one quotient bit a cycle
// from a chosen top bit down, with saturation. Depends on wlf_pkg.
module wlf_div #(
    parameter int FRAC_BITS = wlf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_a,
    input  logic signed [63:0]  i_b,
    input  logic [6:0]          i_top,
    output wlf_pkg::t_unit_out  o_out
);

    logic [127:0] r_num;
    logic [63:0]  r_d, r_rem, r_ql;
    logic         r_qh, r_neg;
    logic [6:0]   r_i;
    logic         r_run, r_fin, r_done;
    logic         r_sat;
    logic signed [63:0] r_res;

    logic [64:0] r2, diff;
    logic        ge;
    logic [63:0] fin_mag;
    logic        fin_sat;

    always_comb begin
        r2   = {r_rem, r_num[r_i]};
        ge   = r2 >= {1'b0, r_d};
        diff = r2 - {1'b0, r_d};
        fin_mag = r_qh ? 64'(wlf_pkg::Q_MAX) : r_ql;
        fin_sat = r_qh | fin_mag[63];
        if (fin_mag[63]) begin
            fin_mag = 64'(wlf_pkg::Q_MAX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                if (i_b == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run && r_i == '0) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {64'd0, wlf_pkg::f_mag(i_a)} << FRAC_BITS;
            r_d   <= wlf_pkg::f_mag(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_rem <= '0;
            r_ql  <= '0;
            r_qh  <= 1'b0;
            r_i   <= i_top;
            if (i_b == '0) begin
                // divide by zero: zero over zero is zero, else full scale
                r_sat <= (i_a != '0);
                r_res <= (i_a == '0) ? 64'sd0 : (i_a[63] ? -wlf_pkg::Q_MAX : wlf_pkg::Q_MAX);
            end
        end else if (r_run) begin
            r_rem <= ge ? diff[63:0] : r2[63:0];
            r_ql  <= {r_ql[62:0], ge};
            if (r_i[6] && ge) begin
                r_qh <= 1'b1;
            end
            r_i <= r_i - 7'd1;
        end else if (r_fin) begin
            r_sat <= fin_sat;
            r_res <= r_neg ? -$signed(fin_mag) : $signed(fin_mag);
        end
    end

    assign o_out = '{done: r_done, sat: r_sat, res: r_res};

endmodule

@@ hw/rtl/wlf_sqrt.sv @@
`timescale 1ns / 1ps
// Fixed-point square root floor(sqrt(a << FRAC_BITS)), digit recurrence,
// one root bit a cycle for all 64 root bits. Depends on wlf_pkg.
module wlf_sqrt #(
    parameter int FRAC_BITS = wlf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_a,
    output wlf_pkg::t_unit_out  o_out
);

    logic [127:0] r_num;
    logic [65:0]  r_rem;
    logic [63:0]  r_root;
    logic [5:0]   r_k;
    logic         r_run, r_done;
    logic signed [63:0] r_res;

    logic [67:0] rem4, trial, diff;
    logic        ge;

    always_comb begin
        rem4  = {r_rem, r_num[127:126]};
        trial = {2'b00, r_root, 2'b01};
        ge    = rem4 >= trial;
        diff  = rem4 - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_a <= 64'sd0) begin
                    r_done <= 1'b1;
                end else begin
                    r_run <= 1'b1;
                end
            end else if (r_run && r_k == '0) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= {64'd0, i_a} << FRAC_BITS;
            r_rem  <= '0;
            r_root <= '0;
            r_k    <= 6'd63;
            r_res  <= '0;
        end else if (r_run) begin
            r_rem  <= ge ? diff[65:0] : rem4[65:0];
            r_root <= {r_root[62:0], ge};
            r_num  <= r_num << 2;
            r_k    <= r_k - 6'd1;
            if (r_k == '0) begin
                r_res <= $signed({r_root[62:0], ge});
            end
        end
    end

    assign o_out = '{done: r_done, sat: 1'b0, res: r_res};

endmodule

@@ hw/rtl/weighted_line_fit_top.sv @@
`timescale 1ns / 1ps
// Weighted least-squares line fit: point memory, fit sequencer and shared units.
// Depends on wlf_pkg, wlf_mul, wlf_div and wlf_sqrt.
//
// A point is taken when start is high and busy is low. Loading a point with
// nonzero sigma, while the memory has room, runs the one-bit-a-cycle divider to
// form the 1/sigma scale; other points go straight to the write. The point marked
// last starts the fit, which walks the point memory two or three times through
// the shared multiplier, with seven or eight 128-bit divisions and two or three
// 64-step square roots between and after the passes, unless it ends early.
// The result appears on the o_ ports for one cycle with o_strobe high; the
// receiver cannot hold it, so it must take it in that cycle. busy drops with
// the strobe, and no reset clearing pass is needed.
module weighted_line_fit_top #(
    parameter int MAX_POINTS = wlf_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = wlf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  i_x_value,
    input  logic signed [31:0]  i_y_value,
    input  logic [31:0]         i_sigma,
    input  logic                i_upper_limit,
    input  logic                i_last,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data,
    output logic                o_strobe,
    output logic signed [31:0]  o_intercept,
    output logic signed [31:0]  o_slope,
    output logic [31:0]         o_intercept_error,
    output logic [31:0]         o_slope_error,
    output logic [1:0]          o_status
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam int NS = 34;

    typedef enum logic [NS-1:0] {
        S_IDLE    = 34'd1 << 0,
        S_P_RECIP = 34'd1 << 1,
        S_P_WRITE = 34'd1 << 2,
        S_F_START = 34'd1 << 3,
        S_L1_RD   = 34'd1 << 4,
        S_L1_W    = 34'd1 << 5,
        S_L1_X    = 34'd1 << 6,
        S_L1_V    = 34'd1 << 7,
        S_CHK1    = 34'd1 << 8,
        S_M_DIV   = 34'd1 << 9,
        S_L2_RD   = 34'd1 << 10,
        S_L2_T    = 34'd1 << 11,
        S_L2_U    = 34'd1 << 12,
        S_L2_TU   = 34'd1 << 13,
        S_L2_TT   = 34'd1 << 14,
        S_CHK2    = 34'd1 << 15,
        S_B_DIV   = 34'd1 << 16,
        S_A_MUL   = 34'd1 << 17,
        S_A_DIV   = 34'd1 << 18,
        S_SA1     = 34'd1 << 19,
        S_SA2     = 34'd1 << 20,
        S_SA3     = 34'd1 << 21,
        S_SA4     = 34'd1 << 22,
        S_SA5     = 34'd1 << 23,
        S_SB1     = 34'd1 << 24,
        S_SB2     = 34'd1 << 25,
        S_L3_RD   = 34'd1 << 26,
        S_L3_M    = 34'd1 << 27,
        S_L3_R    = 34'd1 << 28,
        S_SC1     = 34'd1 << 29,
        S_SC2     = 34'd1 << 30,
        S_SC3     = 34'd1 << 31,
        S_SC4     = 34'd1 << 32,
        S_FINAL   = 34'd1 << 33
    } t_state;

    typedef enum logic [1:0] {
        U_NONE,
        U_MUL,
        U_DIV,
        U_SQRT
    } t_unit;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] v;
        logic [31:0]        inv;
    } t_entry;

    t_entry mem [MAX_POINTS];
    t_entry r_rd;

    t_state r_state;
    logic   r_we, r_usew, r_issued, r_last;
    logic   r_force, r_ovf, r_zero, r_tiny, r_sat;
    logic [1:0] r_early;
    logic [CW-1:0] r_count, r_idx;
    logic signed [31:0] r_x, r_v;
    logic [31:0] r_sigma, r_inv;
    logic signed [63:0] r_sw, r_sx, r_sv, r_stt, r_stv, r_srs;
    logic signed [63:0] r_w, r_m, r_t, r_u, r_tmp, r_a, r_b, r_siga, r_sigb;

    logic r_strobe;
    logic signed [31:0] r_o_a, r_o_b;
    logic [31:0] r_o_ea, r_o_eb;
    logic [1:0]  r_o_st;

    // load-side scaling of an upper-limit ordinate by 3/4, toward zero
    logic [32:0] y_mag;
    logic [33:0] y_m3;
    logic [31:0] y_q;
    logic signed [31:0] y_store;

    logic signed [63:0] x64, v64, pt_r, den;
    wlf_pkg::t_sres sub_xm, sub_a, add_one, s1, s2, acc;
    logic signed [63:0] acc_in;
    logic last_idx;

    t_unit u_kind;
    logic signed [63:0] u_a, u_b;
    logic [6:0] u_top;
    logic u_pre_sat, u_start, u_done, u_sat;
    logic signed [63:0] u_res;
    logic mul_start, div_start, sqrt_start;
    wlf_pkg::t_unit_out mul_o, div_o, sqrt_o;
    logic sat_set;

    logic a_hi, a_lo, b_hi, b_lo, ea_big, eb_big, clamp_sat;
    logic signed [31:0] cl_a, cl_b;
    logic [31:0] cl_ea, cl_eb;

    always_comb begin
        y_mag = i_y_value[31] ? 33'(-{i_y_value[31], i_y_value}) : {1'b0, i_y_value};
        y_m3  = {y_mag, 1'b0} + {1'b0, y_mag};
        y_q   = y_m3[33:2];
        if (!i_upper_limit) begin
            y_store = i_y_value;
        end else if (i_y_value[31]) begin
            y_store = -$signed(y_q);
        end else begin
            y_store = $signed(y_q);
        end
    end

    always_comb begin
        x64  = {{32{r_rd.x[31]}}, r_rd.x};
        v64  = {{32{r_rd.v[31]}}, r_rd.v};
        pt_r = r_usew ? $signed({32'd0, r_rd.inv}) : ONE_Q;
        den  = $signed({{(64-CW){1'b0}}, r_count - CW'(2)} << FRAC_BITS);
        sub_xm  = wlf_pkg::f_qsub(x64, r_m);
        sub_a   = wlf_pkg::f_qsub(r_sv, r_tmp);
        add_one = wlf_pkg::f_qadd(ONE_Q, r_tmp);
        s1 = wlf_pkg::f_qsub(v64, r_a);
        s2 = wlf_pkg::f_qsub(s1.v, r_tmp);
        last_idx = (r_idx + CW'(1)) == r_count;
    end

    // pick the unit and operands for the current step
    always_comb begin
        u_kind    = U_NONE;
        u_a       = '0;
        u_b       = '0;
        u_top     = wlf_pkg::DIV_TOP_FULL;
        u_pre_sat = 1'b0;
        acc_in    = '0;
        unique case (r_state)
            S_P_RECIP: begin
                u_kind = U_DIV;
                u_a    = ONE_Q;
                u_b    = $signed({32'd0, r_sigma});
                u_top  = 7'(2 * FRAC_BITS);
            end
            S_L1_W:  begin u_kind = U_MUL; u_a = pt_r;  u_b = pt_r; acc_in = r_sw; end
            S_L1_X:  begin u_kind = U_MUL; u_a = x64;   u_b = r_w;  acc_in = r_sx; end
            S_L1_V:  begin u_kind = U_MUL; u_a = v64;   u_b = r_w;  acc_in = r_sv; end
            S_M_DIV: begin u_kind = U_DIV; u_a = r_sx;  u_b = r_sw; end
            S_L2_T: begin
                u_kind    = U_MUL;
                u_a       = sub_xm.v;
                u_b       = pt_r;
                u_pre_sat = sub_xm.sat;
            end
            S_L2_U:  begin u_kind = U_MUL; u_a = v64;   u_b = pt_r; end
            S_L2_TU: begin u_kind = U_MUL; u_a = r_t;   u_b = r_u;  acc_in = r_stv; end
            S_L2_TT: begin u_kind = U_MUL; u_a = r_t;   u_b = r_t;  acc_in = r_stt; end
            S_B_DIV: begin u_kind = U_DIV; u_a = r_stv; u_b = r_stt; end
            S_A_MUL: begin u_kind = U_MUL; u_a = r_sx;  u_b = r_b; end
            S_A_DIV: begin
                u_kind    = U_DIV;
                u_a       = sub_a.v;
                u_b       = r_sw;
                u_pre_sat = sub_a.sat;
            end
            S_SA1:   begin u_kind = U_MUL;  u_a = r_sx;  u_b = r_sx; end
            S_SA2:   begin u_kind = U_DIV;  u_a = r_tmp; u_b = r_sw; end
            S_SA3:   begin u_kind = U_DIV;  u_a = r_tmp; u_b = r_stt; end
            S_SA4: begin
                u_kind    = U_DIV;
                u_a       = add_one.v;
                u_b       = r_sw;
                u_pre_sat = add_one.sat;
            end
            S_SA5:   begin u_kind = U_SQRT; u_a = r_tmp; end
            S_SB1:   begin u_kind = U_DIV;  u_a = ONE_Q; u_b = r_stt; end
            S_SB2:   begin u_kind = U_SQRT; u_a = r_tmp; end
            S_L3_M:  begin u_kind = U_MUL;  u_a = r_b;   u_b = x64; end
            S_L3_R: begin
                u_kind    = U_MUL;
                u_a       = s2.v;
                u_b       = s2.v;
                u_pre_sat = s1.sat | s2.sat;
                acc_in    = r_srs;
            end
            S_SC1:   begin u_kind = U_DIV;  u_a = r_srs;  u_b = den; end
            S_SC2:   begin u_kind = U_SQRT; u_a = r_tmp; end
            S_SC3:   begin u_kind = U_MUL;  u_a = r_siga; u_b = r_tmp; end
            S_SC4:   begin u_kind = U_MUL;  u_a = r_sigb; u_b = r_tmp; end
            default: begin u_kind = U_NONE; end
        endcase
    end

    always_comb begin
        u_start    = (u_kind != U_NONE) && !r_issued;
        mul_start  = u_start && (u_kind == U_MUL);
        div_start  = u_start && (u_kind == U_DIV);
        sqrt_start = u_start && (u_kind == U_SQRT);
        u_done = mul_o.done | div_o.done | sqrt_o.done;
        if (mul_o.done) begin
            u_res = mul_o.res;
            u_sat = mul_o.sat;
        end else if (div_o.done) begin
            u_res = div_o.res;
            u_sat = div_o.sat;
        end else begin
            u_res = sqrt_o.res;
            u_sat = sqrt_o.sat;
        end
        acc     = wlf_pkg::f_qadd(acc_in, u_res);
        sat_set = (u_start & u_pre_sat) | (r_issued & u_done & (u_sat | acc.sat));
    end

    // final clamps to the result fields
    always_comb begin
        a_hi   = r_a > wlf_pkg::I32_MAX;
        a_lo   = r_a < wlf_pkg::I32_MIN;
        b_hi   = r_b > wlf_pkg::I32_MAX;
        b_lo   = r_b < wlf_pkg::I32_MIN;
        ea_big = !r_siga[63] && (|r_siga[62:32]);
        eb_big = !r_sigb[63] && (|r_sigb[62:32]);
        cl_a   = a_hi ? 32'sh7FFF_FFFF : (a_lo ? 32'sh8000_0000 : r_a[31:0]);
        cl_b   = b_hi ? 32'sh7FFF_FFFF : (b_lo ? 32'sh8000_0000 : r_b[31:0]);
        cl_ea  = r_siga[63] ? 32'd0 : (ea_big ? 32'hFFFF_FFFF : r_siga[31:0]);
        cl_eb  = r_sigb[63] ? 32'd0 : (eb_big ? 32'hFFFF_FFFF : r_sigb[31:0]);
        clamp_sat = a_hi | a_lo | b_hi | b_lo | r_siga[63] | ea_big | r_sigb[63] | eb_big;
    end

    wlf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (u_a),
        .i_b     (u_b),
        .o_out   (mul_o)
    );

    wlf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (u_a),
        .i_b     (u_b),
        .i_top   (u_top),
        .o_out   (div_o)
    );

    wlf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_a     (u_a),
        .o_out   (sqrt_o)
    );

    // point memory: written only while loading; read every cycle at r_idx, but the read is used only while fitting
    always_ff @(posedge i_clk) begin
        if (r_state == S_P_WRITE && r_count < CW'(MAX_POINTS)) begin
            mem[r_count[AW-1:0]] <= '{x: r_x, v: r_v, inv: r_inv};
        end
        r_rd <= mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_we     <= 1'b1;
            r_usew   <= 1'b0;
            r_issued <= 1'b0;
            r_count  <= '0;
            r_idx    <= '0;
            r_force  <= 1'b0;
            r_ovf    <= 1'b0;
            r_zero   <= 1'b0;
            r_tiny   <= 1'b0;
            r_sat    <= 1'b0;
            r_early  <= wlf_pkg::ST_OK;
            r_strobe <= 1'b0;
            r_sw     <= '0;
            r_sx     <= '0;
            r_sv     <= '0;
            r_stt    <= '0;
            r_stv    <= '0;
            r_srs    <= '0;
        end else begin
            r_strobe <= 1'b0;
            r_sat    <= r_sat | sat_set;
            if (i_cfg_wr_en) begin
                r_we <= i_cfg_wr_data;
            end
            if (u_start) begin
                r_issued <= 1'b1;
            end
            if (r_issued && u_done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x     <= i_x_value;
                        r_v     <= y_store;
                        r_sigma <= i_sigma;
                        r_last  <= i_last;
                        r_inv   <= '0;
                        if (i_upper_limit) begin
                            r_force <= 1'b1;
                        end
                        if (r_count < CW'(MAX_POINTS)) begin
                            if (i_sigma == '0) begin
                                r_zero  <= 1'b1;
                                r_state <= S_P_WRITE;
                            end else begin
                                r_state <= S_P_RECIP;
                            end
                        end else begin
                            r_ovf   <= 1'b1;
                            r_state <= S_P_WRITE;
                        end
                    end
                end
                S_P_RECIP: begin
                    if (r_issued && u_done) begin
                        if (|u_res[63:32]) begin
                            r_inv  <= 32'hFFFF_FFFF;
                            r_tiny <= 1'b1;
                        end else begin
                            r_inv <= u_res[31:0];
                        end
                        r_state <= S_P_WRITE;
                    end
                end
                S_P_WRITE: begin
                    if (r_count < CW'(MAX_POINTS)) begin
                        r_count <= r_count + CW'(1);
                    end
                    r_state <= r_last ? S_F_START : S_IDLE;
                end
                S_F_START: begin
                    r_usew  <= r_we & !r_force;
                    r_sat   <= r_we & !r_force & r_tiny;
                    r_early <= wlf_pkg::ST_OK;
                    r_idx   <= '0;
                    if (r_ovf) begin
                        r_early <= wlf_pkg::ST_OVF;
                        r_state <= S_FINAL;
                    end else if (r_we && !r_force && r_zero) begin
                        r_early <= wlf_pkg::ST_ZERO;
                        r_state <= S_FINAL;
                    end else if (r_count == '0) begin
                        r_state <= S_CHK1;
                    end else begin
                        r_state <= S_L1_RD;
                    end
                end
                S_L1_RD: r_state <= S_L1_W;
                S_L1_W: begin
                    if (r_issued && u_done) begin
                        r_w     <= u_res;
                        r_sw    <= acc.v;
                        r_state <= S_L1_X;
                    end
                end
                S_L1_X: begin
                    if (r_issued && u_done) begin
                        r_sx    <= acc.v;
                        r_state <= S_L1_V;
                    end
                end
                S_L1_V: begin
                    if (r_issued && u_done) begin
                        r_sv <= acc.v;
                        if (last_idx) begin
                            r_state <= S_CHK1;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_L1_RD;
                        end
                    end
                end
                S_CHK1: begin
                    if (r_sw <= 64'sd0) begin
                        r_early <= wlf_pkg::ST_ZERO;
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= S_M_DIV;
                    end
                end
                S_M_DIV: begin
                    if (r_issued && u_done) begin
                        r_m     <= u_res;
                        r_idx   <= '0;
                        r_state <= S_L2_RD;
                    end
                end
                S_L2_RD: r_state <= S_L2_T;
                S_L2_T: begin
                    if (r_issued && u_done) begin
                        r_t     <= u_res;
                        r_state <= S_L2_U;
                    end
                end
                S_L2_U: begin
                    if (r_issued && u_done) begin
                        r_u     <= u_res;
                        r_state <= S_L2_TU;
                    end
                end
                S_L2_TU: begin
                    if (r_issued && u_done) begin
                        r_stv   <= acc.v;
                        r_state <= S_L2_TT;
                    end
                end
                S_L2_TT: begin
                    if (r_issued && u_done) begin
                        r_stt <= acc.v;
                        if (last_idx) begin
                            r_state <= S_CHK2;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_L2_RD;
                        end
                    end
                end
                S_CHK2: begin
                    if (r_stt <= 64'sd0) begin
                        r_early <= wlf_pkg::ST_ZERO;
                        r_state <= S_FINAL;
                    end else begin
                        r_state <= S_B_DIV;
                    end
                end
                S_B_DIV: begin
                    if (r_issued && u_done) begin
                        r_b     <= u_res;
                        r_state <= S_A_MUL;
                    end
                end
                S_A_MUL: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_A_DIV;
                    end
                end
                S_A_DIV: begin
                    if (r_issued && u_done) begin
                        r_a     <= u_res;
                        r_state <= S_SA1;
                    end
                end
                S_SA1: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SA2;
                    end
                end
                S_SA2: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SA3;
                    end
                end
                S_SA3: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SA4;
                    end
                end
                S_SA4: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SA5;
                    end
                end
                S_SA5: begin
                    if (r_issued && u_done) begin
                        r_siga  <= u_res;
                        r_state <= S_SB1;
                    end
                end
                S_SB1: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SB2;
                    end
                end
                S_SB2: begin
                    if (r_issued && u_done) begin
                        r_sigb <= u_res;
                        r_idx  <= '0;
                        r_state <= r_usew ? S_FINAL : S_L3_RD;
                    end
                end
                S_L3_RD: r_state <= S_L3_M;
                S_L3_M: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_L3_R;
                    end
                end
                S_L3_R: begin
                    if (r_issued && u_done) begin
                        r_srs <= acc.v;
                        if (!last_idx) begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_L3_RD;
                        end else if (r_count > CW'(2)) begin
                            r_state <= S_SC1;
                        end else begin
                            // two points or fewer: no spread estimate
                            r_tmp   <= '0;
                            r_state <= S_SC3;
                        end
                    end
                end
                S_SC1: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SC2;
                    end
                end
                S_SC2: begin
                    if (r_issued && u_done) begin
                        r_tmp   <= u_res;
                        r_state <= S_SC3;
                    end
                end
                S_SC3: begin
                    if (r_issued && u_done) begin
                        r_siga  <= u_res;
                        r_state <= S_SC4;
                    end
                end
                S_SC4: begin
                    if (r_issued && u_done) begin
                        r_sigb  <= u_res;
                        r_state <= S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_strobe <= 1'b1;
                    if (r_early != wlf_pkg::ST_OK) begin
                        r_o_a  <= '0;
                        r_o_b  <= '0;
                        r_o_ea <= '0;
                        r_o_eb <= '0;
                        r_o_st <= r_early;
                    end else begin
                        r_o_a  <= cl_a;
                        r_o_b  <= cl_b;
                        r_o_ea <= cl_ea;
                        r_o_eb <= cl_eb;
                        r_o_st <= (r_sat | clamp_sat) ? wlf_pkg::ST_SAT : wlf_pkg::ST_OK;
                    end
                    // drop the set and return to loading
                    r_count <= '0;
                    r_force <= 1'b0;
                    r_ovf   <= 1'b0;
                    r_zero  <= 1'b0;
                    r_tiny  <= 1'b0;
                    r_sw    <= '0;
                    r_sx    <= '0;
                    r_sv    <= '0;
                    r_stt   <= '0;
                    r_stv   <= '0;
                    r_srs   <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy              = (r_state != S_IDLE);
    assign o_strobe          = r_strobe;
    assign o_intercept       = r_o_a;
    assign o_slope           = r_o_b;
    assign o_intercept_error = r_o_ea;
    assign o_slope_error     = r_o_eb;
    assign o_status          = r_o_st;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while sequencer still busy");

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({mul_start, div_start, sqrt_start}))
        else $error("more than one arithmetic unit started");

    a_no_reissue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issued && !u_done |-> !u_start)
        else $error("unit started while a result is outstanding");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count beyond memory depth");

endmodule
